// ----- rtl/vnth_pkg.sv -----
`timescale 1ns / 1ps
// vnth_pkg: shared constants, register codes and smoothstep weight functions
// for the value-noise terrain height block. No dependencies.
package vnth_pkg;

  localparam int NSTG = 15;

  // register index (paddr[4:3])
  localparam logic [1:0] REG_SEED  = 2'd0;
  localparam logic [1:0] REG_WATER = 2'd1;
  localparam logic [1:0] REG_TREE  = 2'd2;

  localparam logic [63:0] SEED_RST  = 64'd0;
  localparam logic [7:0]  WATER_RST = 8'd63;
  localparam logic [6:0]  TREE_RST  = 7'd3;

  // reciprocal multipliers
  localparam logic [30:0] DIV25_M35  = 31'd1374389535;
  localparam logic [32:0] DIV25_M37  = 33'd5497558139;
  localparam logic [30:0] DIV100_M37 = 31'd1374389535;

  // offset corrections for the biased coordinates
  localparam logic [33:0] C_QOFF = 34'd42949672;
  localparam logic [5:0]  C_ROFF = 6'd48;
  localparam logic [33:0] F_QOFF = 34'd171798691;
  localparam logic [4:0]  F_ROFF = 5'd21;

  localparam logic signed [29:0] HASH_KX = 30'sd374761393;
  localparam logic signed [30:0] HASH_KZ = 31'sd668265263;
  localparam logic [30:0]        MIX_K   = 31'd1274126177;
  localparam logic signed [39:0] TREE_KX = 40'sd341873128712;
  localparam logic signed [37:0] TREE_KZ = 38'sd132897987541;

  localparam logic [37:0] SUM_BIAS = 38'h08_0000_0000;

  localparam longint unsigned C_CUBE = 64'd125000;
  localparam longint unsigned F_CUBE = 64'd15625;

  function automatic logic [31:0] weight_c(int unsigned r);
    longint unsigned num;
    num = longint'(r * r * (150 - 2 * r));
    return 32'((num << 32) / C_CUBE);
  endfunction

  function automatic logic [31:0] weight_f(int unsigned r);
    longint unsigned num;
    num = longint'(r * r * (75 - 2 * r));
    return 32'((num << 32) / F_CUBE);
  endfunction

endpackage

// ----- rtl/vnth_if.sv -----
`timescale 1ns / 1ps
// Stream interfaces for column coordinates in and height results out.
// No dependencies.
interface vnth_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] world_x;
  logic signed [31:0] world_z;
  modport source (output valid, output world_x, output world_z, input ready);
  modport sink (input valid, input world_x, input world_z, output ready);
endinterface

interface vnth_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] surface_height;
  logic       tree_roll;
  modport source (output valid, output surface_height, output tree_roll, input ready);
  modport sink (input valid, input surface_height, input tree_roll, output ready);
endinterface

// ----- rtl/vnth_mix.sv -----
`timescale 1ns / 1ps
// vnth_mix: two-stage position hash mixer, low 31 bits of the result.
// Depends on vnth_pkg.
module vnth_mix (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [63:0] n,
  output logic [30:0] h
);

  logic [46:0] a;
  logic [54:0] pl_full;
  logic [53:0] ph_full;
  logic [46:0] pl_r;
  logic [22:0] ph_r;
  logic [46:0] m;
  logic [30:0] h_r, h_nxt;

  assign a       = n[46:0] ^ n[59:13];
  assign pl_full = 55'(a[23:0]) * 55'(vnth_pkg::MIX_K);
  assign ph_full = 54'(a[46:24]) * 54'(vnth_pkg::MIX_K);
  assign m       = pl_r + {ph_r, 24'd0};
  assign h_nxt   = m[30:0] ^ m[46:16];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pl_r <= pl_full[46:0];
      ph_r <= ph_full[22:0];
    end
    if (en[1]) begin
      h_r <= h_nxt;
    end
  end

  assign h = h_r;

endmodule

// ----- rtl/vnth_lerp.sv -----
`timescale 1ns / 1ps
// vnth_lerp: two-stage Q0.32 linear blend a + ((b - a) * w) >> 32.
// No dependencies.
module vnth_lerp (
  input  logic        clk,
  input  logic [1:0]  en,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] w,
  output logic [31:0] y
);

  logic signed [32:0] d;
  logic signed [65:0] prod_nxt, prod_r;
  logic signed [65:0] sh;
  logic [31:0]        a_r, y_r;

  assign d        = $signed({1'b0, b}) - $signed({1'b0, a});
  assign prod_nxt = d * $signed({1'b0, w});
  assign sh       = prod_r >>> 32;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod_r <= prod_nxt;
      a_r    <= a;
    end
    if (en[1]) begin
      y_r <= a_r + sh[31:0];
    end
  end

  assign y = y_r;

endmodule

// ----- rtl/vnth_lattice.sv -----
`timescale 1ns / 1ps
// vnth_lattice: splits one coordinate into cell index and smoothstep weight
// for both octaves, four stages. Depends on vnth_pkg.
module vnth_lattice (
  input  logic               clk,
  input  logic [3:0]         en,
  input  logic signed [31:0] coord,
  output logic signed [33:0] x0c,
  output logic [31:0]        wc,
  output logic signed [33:0] x0f,
  output logic [31:0]        wf
);

  logic [31:0] wc_tab [64];
  logic [31:0] wf_tab [32];

  for (genvar i = 0; i < 64; i++) begin : g_wc
    assign wc_tab[i] = (i < 50) ? vnth_pkg::weight_c(i) : 32'd0;
  end
  for (genvar i = 0; i < 32; i++) begin : g_wf
    assign wf_tab[i] = (i < 25) ? vnth_pkg::weight_f(i) : 32'd0;
  end

  // stage 1: biased coordinate and reciprocal products
  logic [31:0] u, u_r;
  logic [32:0] u2, u2b;
  logic [61:0] prodc_r;
  logic [65:0] prodf_r;

  assign u  = {~coord[31], coord[30:0]};
  assign u2 = 33'(u) + 33'd1000;

  // stage 2: quotients and remainders
  logic [26:0] q1, q1_r;
  logic [27:0] q2, q2_r;
  logic [31:0] t1;
  logic [32:0] t2;
  logic [5:0]  r1_r;
  logic [4:0]  r2_r;

  assign q1  = prodc_r[61:35];
  assign q2  = prodf_r[64:37];
  assign u2b = 33'(u_r) + 33'd1000;
  assign t1  = u_r - 32'(q1) * 32'd50;
  assign t2  = u2b - 33'(q2) * 33'd25;

  // stage 3: floor correction
  logic        lowc, hif, lowf;
  logic [5:0]  r2x2, rfa;
  logic [4:0]  rfb;
  logic [28:0] qf;
  logic [5:0]  rc_nxt, rc_r;
  logic [4:0]  rf_nxt, rf_r;
  logic signed [33:0] x0c_nxt, x0f_nxt, x0c_r, x0f_r;

  assign lowc    = r1_r < vnth_pkg::C_ROFF;
  assign x0c_nxt = $signed(34'(q1_r) - vnth_pkg::C_QOFF - 34'(lowc));
  assign rc_nxt  = lowc ? r1_r + 6'd2 : r1_r - vnth_pkg::C_ROFF;
  assign r2x2    = {r2_r, 1'b0};
  assign hif     = r2x2 >= 6'd25;
  assign qf      = {q2_r, hif};
  assign rfa     = hif ? r2x2 - 6'd25 : r2x2;
  assign rfb     = rfa[4:0];
  assign lowf    = rfb < vnth_pkg::F_ROFF;
  assign x0f_nxt = $signed(34'(qf) - vnth_pkg::F_QOFF - 34'(lowf));
  assign rf_nxt  = lowf ? rfb + 5'd4 : rfb - vnth_pkg::F_ROFF;

  // stage 4: weights
  logic signed [33:0] x0c_o, x0f_o;
  logic [31:0]        wc_o, wf_o;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      u_r     <= u;
      prodc_r <= 62'(u[31:1]) * 62'(vnth_pkg::DIV25_M35);
      prodf_r <= 66'(u2) * 66'(vnth_pkg::DIV25_M37);
    end
    if (en[1]) begin
      q1_r <= q1;
      q2_r <= q2;
      r1_r <= t1[5:0];
      r2_r <= t2[4:0];
    end
    if (en[2]) begin
      x0c_r <= x0c_nxt;
      x0f_r <= x0f_nxt;
      rc_r  <= rc_nxt;
      rf_r  <= rf_nxt;
    end
    if (en[3]) begin
      x0c_o <= x0c_r;
      x0f_o <= x0f_r;
      wc_o  <= wc_tab[rc_r];
      wf_o  <= wf_tab[rf_r];
    end
  end

  assign x0c = x0c_o;
  assign x0f = x0f_o;
  assign wc  = wc_o;
  assign wf  = wf_o;

endmodule

// ----- rtl/vnth_octave.sv -----
`timescale 1ns / 1ps
// vnth_octave: corner hashes and bilinear blend of one noise octave, eight stages.
// Depends on vnth_pkg, vnth_mix, vnth_lerp.
module vnth_octave (
  input  logic               clk,
  input  logic [7:0]         en,
  input  logic [63:0]        seed,
  input  logic signed [33:0] x0,
  input  logic signed [33:0] z0,
  input  logic [31:0]        wx,
  input  logic [31:0]        wz,
  output logic [31:0]        noise
);

  logic signed [33:0] x1, z1;
  logic signed [63:0] xk0_r, xk1_r, zk0_r, zk1_r;
  logic signed [63:0] xk0_nxt, xk1_nxt, zk0_nxt, zk1_nxt;
  logic [63:0]        n_r [4];
  logic [30:0]        h [4];
  logic [31:0]        q [4];
  logic [31:0]        wx_r [4];
  logic [31:0]        wz_r [6];
  logic [31:0]        v0, v1;

  assign x1      = x0 + 34'sd1;
  assign z1      = z0 + 34'sd1;
  assign xk0_nxt = x0 * vnth_pkg::HASH_KX;
  assign xk1_nxt = x1 * vnth_pkg::HASH_KX;
  assign zk0_nxt = z0 * vnth_pkg::HASH_KZ;
  assign zk1_nxt = z1 * vnth_pkg::HASH_KZ;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xk0_r <= xk0_nxt;
      xk1_r <= xk1_nxt;
      zk0_r <= zk0_nxt;
      zk1_r <= zk1_nxt;
    end
    if (en[1]) begin
      n_r[0] <= seed + xk0_r + zk0_r;
      n_r[1] <= seed + xk1_r + zk0_r;
      n_r[2] <= seed + xk0_r + zk1_r;
      n_r[3] <= seed + xk1_r + zk1_r;
    end
    for (int i = 0; i < 4; i++) begin
      if (en[i]) begin
        wx_r[i] <= (i == 0) ? wx : wx_r[(i == 0) ? 0 : i - 1];
      end
    end
    for (int i = 0; i < 6; i++) begin
      if (en[i]) begin
        wz_r[i] <= (i == 0) ? wz : wz_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  for (genvar i = 0; i < 4; i++) begin : g_corner
    vnth_mix u_mix (
      .clk (clk),
      .en  (en[3:2]),
      .n   (n_r[i]),
      .h   (h[i])
    );
    // 31-bit hash to Q0.32: 2h plus one for the upper half
    assign q[i] = {h[i], h[i][30]};
  end

  vnth_lerp u_lerp_z0 (
    .clk (clk),
    .en  (en[5:4]),
    .a   (q[0]),
    .b   (q[1]),
    .w   (wx_r[3]),
    .y   (v0)
  );

  vnth_lerp u_lerp_z1 (
    .clk (clk),
    .en  (en[5:4]),
    .a   (q[2]),
    .b   (q[3]),
    .w   (wx_r[3]),
    .y   (v1)
  );

  vnth_lerp u_lerp_out (
    .clk (clk),
    .en  (en[7:6]),
    .a   (v0),
    .b   (v1),
    .w   (wz_r[5]),
    .y   (noise)
  );

endmodule

// ----- rtl/vnth_tree.sv -----
`timescale 1ns / 1ps
// vnth_tree: tree-roll hash, modulo-100 test and edge margin, thirteen stages.
// Depends on vnth_pkg, vnth_mix.
module vnth_tree (
  input  logic               clk,
  input  logic [12:0]        en,
  input  logic [63:0]        seed,
  input  logic [6:0]         tree_percent,
  input  logic signed [31:0] wx,
  input  logic signed [31:0] wz,
  output logic               ok
);

  logic signed [63:0] xl_nxt, xh_nxt, zl_nxt, zh_nxt;
  logic signed [63:0] xl_r, xh_r, zl_r, zh_r, px_r, pz_r;
  logic [63:0]        p_r;
  logic [30:0]        h, h_r;
  logic [61:0]        prod_r;
  logic [24:0]        qd;
  logic [30:0]        rem;
  logic [6:0]         v_r;
  logic               pass_r;
  logic               margin;
  logic               mg_r [8];
  logic               ok_r [5];

  assign xl_nxt = $signed({1'b0, wx[15:0]}) * vnth_pkg::TREE_KX;
  assign xh_nxt = $signed(wx[31:16]) * vnth_pkg::TREE_KX;
  assign zl_nxt = $signed({1'b0, wz[15:0]}) * vnth_pkg::TREE_KZ;
  assign zh_nxt = $signed(wz[31:16]) * vnth_pkg::TREE_KZ;
  assign margin = (wx[3:0] inside {[4'd3:4'd12]}) && (wz[3:0] inside {[4'd3:4'd12]});
  assign qd     = prod_r[61:37];
  assign rem    = h_r - 31'(qd) * 31'd100;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      xl_r <= xl_nxt;
      xh_r <= xh_nxt;
      zl_r <= zl_nxt;
      zh_r <= zh_nxt;
    end
    if (en[1]) begin
      px_r <= xl_r + (xh_r <<< 16);
      pz_r <= zl_r + (zh_r <<< 16);
    end
    if (en[2]) begin
      p_r <= seed + px_r + pz_r;
    end
    if (en[5]) begin
      prod_r <= 62'(h) * 62'(vnth_pkg::DIV100_M37);
      h_r    <= h;
    end
    if (en[6]) begin
      v_r <= rem[6:0];
    end
    if (en[7]) begin
      pass_r <= v_r < tree_percent;
    end
    for (int i = 0; i < 8; i++) begin
      if (en[i]) begin
        mg_r[i] <= (i == 0) ? margin : mg_r[(i == 0) ? 0 : i - 1];
      end
    end
    for (int i = 0; i < 5; i++) begin
      if (en[i + 8]) begin
        ok_r[i] <= (i == 0) ? (mg_r[7] && pass_r) : ok_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  vnth_mix u_mix (
    .clk (clk),
    .en  (en[4:3]),
    .n   (p_r),
    .h   (h)
  );

  assign ok = ok_r[4];

endmodule

// ----- rtl/value_noise_terrain_height.sv -----
`timescale 1ns / 1ps
// value_noise_terrain_height: top level, stage control, config registers, output.
// Depends on vnth_pkg, vnth_if, vnth_lattice, vnth_octave, vnth_tree.
//
// Usage:
//   in_ch  : one transaction per column (world_x, world_z), valid/ready.
//   out_ch : one transaction per column (surface_height, tree_roll), in order.
//   cfg_*  : APB write/read of world_seed (0x00), shore_height (0x08),
//            tree_percent (0x10); write only while the block is idle.
// Throughput: one column per cycle while out_ch takes results, set by a fully
// pipelined datapath of 15 register stages (lattice split, hash multipliers,
// blend multipliers).
// Each stage has a valid bit; a stage loads when empty or when the one after
// it moves, so bubbles close up and in_ch.ready stays high while the output
// register holds a result that out_ch has not taken yet, until all stages fill.
// A stall loses and repeats nothing; held results stay stable.
// Reset (rst_n low, synchronous) empties the pipeline and restores the
// registers to seed 0, shore height 63, tree percent 3.
module value_noise_terrain_height (
  input  logic        clk,
  input  logic        rst_n,
  vnth_in_if.sink     in_ch,
  vnth_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int NS = vnth_pkg::NSTG;

  logic [63:0] seed_r;
  logic [7:0]  water_r;
  logic [6:0]  tree_r;
  logic        wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r  <= vnth_pkg::SEED_RST;
      water_r <= vnth_pkg::WATER_RST;
      tree_r  <= vnth_pkg::TREE_RST;
    end else if (wr) begin
      case (cfg_paddr[4:3])
        vnth_pkg::REG_SEED:  seed_r  <= cfg_pwdata;
        vnth_pkg::REG_WATER: water_r <= cfg_pwdata[7:0];
        vnth_pkg::REG_TREE:  tree_r  <= cfg_pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:3])
      vnth_pkg::REG_SEED:  cfg_prdata = seed_r;
      vnth_pkg::REG_WATER: cfg_prdata = 64'(water_r);
      vnth_pkg::REG_TREE:  cfg_prdata = 64'(tree_r);
      default:             cfg_prdata = 64'd0;
    endcase
  end

  // stage control
  logic [NS-1:0] v_r, ld;

  always_comb begin
    ld[NS-1] = !v_r[NS-1] || out_ch.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      ld[k] = !v_r[k] || ld[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (ld[k]) begin
          v_r[k] <= (k == 0) ? in_ch.valid : v_r[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  assign in_ch.ready = ld[0];

  // stage 0: input register
  logic signed [31:0] wx_r, wz_r;

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      wx_r <= in_ch.world_x;
      wz_r <= in_ch.world_z;
    end
  end

  logic signed [33:0] x0c, x0f, z0c, z0f;
  logic [31:0]        wxc, wxf, wzc, wzf;
  logic [31:0]        n1, n2;
  logic               ok;

  vnth_lattice u_lat_x (
    .clk   (clk),
    .en    (ld[4:1]),
    .coord (wx_r),
    .x0c   (x0c),
    .wc    (wxc),
    .x0f   (x0f),
    .wf    (wxf)
  );

  vnth_lattice u_lat_z (
    .clk   (clk),
    .en    (ld[4:1]),
    .coord (wz_r),
    .x0c   (z0c),
    .wc    (wzc),
    .x0f   (z0f),
    .wf    (wzf)
  );

  vnth_octave u_oct_coarse (
    .clk   (clk),
    .en    (ld[12:5]),
    .seed  (seed_r),
    .x0    (x0c),
    .z0    (z0c),
    .wx    (wxc),
    .wz    (wzc),
    .noise (n1)
  );

  vnth_octave u_oct_fine (
    .clk   (clk),
    .en    (ld[12:5]),
    .seed  (seed_r),
    .x0    (x0f),
    .z0    (z0f),
    .wx    (wxf),
    .wz    (wzf),
    .noise (n2)
  );

  vnth_tree u_tree (
    .clk          (clk),
    .en           (ld[13:1]),
    .seed         (seed_r),
    .tree_percent (tree_r),
    .wx           (wx_r),
    .wz           (wz_r),
    .ok           (ok)
  );

  // stage 13: sum, integer part truncated toward zero
  logic signed [37:0] tot;
  logic signed [5:0]  hi;
  logic signed [5:0]  t_nxt, t_r;

  assign tot   = $signed(38'(n1) * 38'd12 + 38'(n2) * 38'd4 - vnth_pkg::SUM_BIAS);
  assign hi    = tot[37:32];
  assign t_nxt = hi + $signed({5'd0, tot[37] && (tot[31:0] != 32'd0)});

  // stage 14: clamp, tree decision, output register
  logic signed [7:0] hv;
  logic [6:0]        height;
  logic [6:0]        height_r;
  logic              roll_r;

  assign hv = 8'sd64 + 8'(t_r);

  always_comb begin
    if (hv < 8'sd56) begin
      height = 7'd56;
    end else if (hv > 8'sd72) begin
      height = 7'd72;
    end else begin
      height = hv[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[13]) begin
      t_r <= t_nxt;
    end
    if (ld[14]) begin
      height_r <= height;
      roll_r   <= ok && (8'(height) > water_r);
    end
  end

  assign out_ch.valid          = v_r[NS-1];
  assign out_ch.surface_height = height_r;
  assign out_ch.tree_roll      = roll_r;

endmodule

// ----- rtl/vnth_checker.sv -----
`timescale 1ns / 1ps
// vnth_checker: port-level assertions for value_noise_terrain_height, and the
// bind that attaches it. Depends on value_noise_terrain_height.
module vnth_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] surface_height,
  input logic       tree_roll
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_height_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (surface_height >= 7'd56 && surface_height <= 7'd72))
    else $error("surface height out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(surface_height) && $stable(tree_roll))
    else $error("stalled result changed");

  a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ready || !out_valid) |-> in_ready)
    else $error("input blocked while output moves");

endmodule

bind value_noise_terrain_height vnth_checker u_vnth_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_ch.valid),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .surface_height (out_ch.surface_height),
  .tree_roll      (out_ch.tree_roll)
);
